FILE: src/clcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and helpers of the character display text writer.
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [3:0] NIBBLE_MASK  = 4'hF;

   localparam logic [2:0] ROWS_MAX     = 3'd4;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;
   localparam logic [1:0] REG_WRAP = 2'd2;

   localparam logic [2:0] ROWS_RESET = 3'd2;
   localparam logic [6:0] COLS_RESET = 7'd16;

   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   typedef struct packed {
      logic       set_position;
      logic [2:0] start_row;
      logic [6:0] start_col;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic       register_select;
      logic [3:0] nibble;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [2:0] rows_in_use;
      logic [6:0] cols_in_use;
      logic       wrap_long_lines;
   } cfg_type;

   // Bytes caused by one item, packed from slot 0 upward
   typedef struct packed {
      logic [2:0][7:0] code_list;
      logic [2:0]      rs_list;
      logic [1:0]      code_count;
      logic [1:0]      next_row;
      logic [7:0]      next_col;
   } plan_type;

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0:    base = 8'h00;
         2'd1:    base = 8'h40;
         2'd2:    base = 8'h14;
         default: base = 8'h54;
      endcase
      return base;
   endfunction

   // Rows at or beyond the rows in use (capped at four) fall back to row 0
   function automatic logic [1:0] clip_row(input logic [2:0] row, input logic [2:0] rows);
      logic [2:0] limit;
      logic [1:0] res;
      limit = (rows > ROWS_MAX) ? ROWS_MAX : rows;
      res   = (row >= limit) ? 2'd0 : row[1:0];
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: src/clcd_planner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_planner
// Works out the bytes and the new cursor for one character item.
// ----------------------------------------------------------------------------
module clcd_planner
   import clcd_pkg::*;
(
   input  req_type    item,
   input  logic [1:0] cursor_row,
   input  logic [7:0] cursor_col,
   input  cfg_type    cfg,
   output plan_type   plan
);

   always_comb begin
      logic [1:0] row;
      logic [7:0] col;
      logic [1:0] n;
      plan = '0;
      row  = cursor_row;
      col  = cursor_col;
      n    = 2'd0;

      if (item.set_position) begin
         row = clip_row(item.start_row, cfg.rows_in_use);
         col = {1'b0, item.start_col};
         plan.code_list[n] = CMD_SET_ADDR | (col + row_base(row));
         plan.rs_list[n]   = RS_INSTR;
         n = n + 2'd1;
      end

      if (cfg.wrap_long_lines && (col >= {1'b0, cfg.cols_in_use})) begin
         row = clip_row({1'b0, row} + 3'd1, cfg.rows_in_use);
         col = 8'd0;
         plan.code_list[n] = CMD_SET_ADDR | (col + row_base(row));
         plan.rs_list[n]   = RS_INSTR;
         n = n + 2'd1;
      end

      case (item.char_code)
         CHAR_NEWLINE: begin
            row = clip_row({1'b0, row} + 3'd1, cfg.rows_in_use);
            plan.code_list[n] = CMD_SET_ADDR | (col + row_base(row));
            plan.rs_list[n]   = RS_INSTR;
         end
         CHAR_RETURN: begin
            row = clip_row({1'b0, row}, cfg.rows_in_use);
            col = 8'd0;
            plan.code_list[n] = CMD_SET_ADDR | (col + row_base(row));
            plan.rs_list[n]   = RS_INSTR;
         end
         default: begin
            plan.code_list[n] = item.char_code;
            plan.rs_list[n]   = RS_DATA;
            col = col + 8'd1;
         end
      endcase

      plan.code_count = n + 2'd1;
      plan.next_row   = row;
      plan.next_col   = col;
   end

endmodule
`default_nettype wire

FILE: src/char_lcd_text_writer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_text_writer_top
// Character display text writer: turns characters into 4-bit bus nibbles.
// ----------------------------------------------------------------------------
// Each accepted item (one character, optionally with a cursor placement)
// produces two to six nibbles on the result channel, one per cycle unless
// the receiver stalls, high nibble of each byte first; last_of_run marks the
// final nibble of the item. An item sits in the input register, then its
// bytes are planned and loaded into the nibble buffer while the cursor is
// updated. The first nibble is offered from the nibble buffer once the item
// has moved there. The nibble serializer sets the pace of items, with the
// next item accepted while the current one drains.
// Registers sit at byte addresses 0 (rows_in_use), 4 (cols_in_use) and
// 8 (wrap_long_lines); write them only while the block is idle.
// ----------------------------------------------------------------------------
module char_lcd_text_writer_top
   import clcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------- config
   cfg_type cfg_ff;
   logic    cfg_write;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows_in_use     <= ROWS_RESET;
         cfg_ff.cols_in_use     <= COLS_RESET;
         cfg_ff.wrap_long_lines <= 1'b0;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            REG_ROWS: cfg_ff.rows_in_use     <= csr_pwdata[2:0];
            REG_COLS: cfg_ff.cols_in_use     <= csr_pwdata[6:0];
            REG_WRAP: cfg_ff.wrap_long_lines <= csr_pwdata[0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ROWS: csr_prdata = {29'd0, cfg_ff.rows_in_use};
         REG_COLS: csr_prdata = {25'd0, cfg_ff.cols_in_use};
         REG_WRAP: csr_prdata = {31'd0, cfg_ff.wrap_long_lines};
         default:  csr_prdata = 32'd0;
      endcase
   end

   // ----------------------------------------------------------- input stage
   logic    in_vld_ff;
   req_type in_item_ff;
   logic    buf_load;

   // Take a new item whenever the input register is empty or moves on.
   assign req_stall = in_vld_ff && !buf_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   // ------------------------------------------------------ planning + cursor
   logic [1:0] cursor_row_ff;
   logic [7:0] cursor_col_ff;
   plan_type   plan;

   clcd_planner u_planner (
      .item       (in_item_ff),
      .cursor_row (cursor_row_ff),
      .cursor_col (cursor_col_ff),
      .cfg        (cfg_ff),
      .plan       (plan)
   );

   // Advance the cursor at the moment the item's bytes enter the buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff <= 2'd0;
         cursor_col_ff <= 8'd0;
      end else if (buf_load) begin
         cursor_row_ff <= plan.next_row;
         cursor_col_ff <= plan.next_col;
      end
   end

   // ------------------------------------------------------- nibble buffer
   logic            buf_vld_ff;
   logic [2:0][7:0] buf_codes_ff;
   logic [2:0]      buf_rs_ff;
   logic [2:0]      nib_last_ff;    // index of the final nibble
   logic [2:0]      nib_idx_ff;
   logic [2:0]      nib_idx_in;
   logic            nib_is_last;
   logic            buf_done;
   logic [7:0]      cur_code;

   assign nib_is_last = (nib_idx_ff == nib_last_ff);
   assign buf_done    = buf_vld_ff && !rsp_stall && nib_is_last;
   assign buf_load    = in_vld_ff && (!buf_vld_ff || buf_done);

   always_comb begin
      if (buf_load) begin
         nib_idx_in = 3'd0;
      end else if (buf_vld_ff && !rsp_stall) begin
         nib_idx_in = nib_idx_ff + 3'd1;
      end else begin
         nib_idx_in = nib_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
         nib_idx_ff <= 3'd0;
      end else begin
         if (buf_load) begin
            buf_vld_ff <= 1'b1;
         end else if (buf_done) begin
            buf_vld_ff <= 1'b0;
         end
         nib_idx_ff <= nib_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_load) begin
         buf_codes_ff <= plan.code_list;
         buf_rs_ff    <= plan.rs_list;
         nib_last_ff  <= {plan.code_count, 1'b0} - 3'd1;
      end
   end

   // Even index: high nibble of the byte, odd index: low nibble.
   assign cur_code = buf_codes_ff[nib_idx_ff[2:1]];

   assign rsp_valid                = buf_vld_ff;
   assign rsp_data.register_select = buf_rs_ff[nib_idx_ff[2:1]];
   assign rsp_data.nibble          = nib_idx_ff[0] ? (cur_code[3:0] & NIBBLE_MASK)
                                                   : (cur_code[7:4] & NIBBLE_MASK);
   assign rsp_data.last_of_run     = nib_is_last;

   // ------------------------------------------------------------ assertions
   // Nibbles of one item leave on consecutive cycles unless stalled.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (buf_vld_ff && !rsp_stall && !nib_is_last) |=> rsp_valid)
      else $error("item run broken before its last nibble");

   // A loaded buffer always starts at the high nibble of its first byte.
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      buf_load |=> (nib_idx_ff == 3'd0) && buf_vld_ff)
      else $error("buffer load did not restart at first nibble");

   // Every item causes at least two and at most six nibbles.
   a_run_length: assert property (@(posedge clock) disable iff (reset)
      buf_vld_ff |-> (nib_last_ff == 3'd1 || nib_last_ff == 3'd3 || nib_last_ff == 3'd5))
      else $error("bad nibble count");

   // A held input item stays valid until it moves into the buffer.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !buf_load) |=> in_vld_ff)
      else $error("held item dropped");

endmodule
`default_nettype wire

FILE: bench/char_lcd_text_writer_top_test.sv
// ----------------------------------------------------------------------------
// char_lcd_text_writer_top_test
// Self-checking bench for the character display text writer.
// ----------------------------------------------------------------------------
// A scripted run of characters, cursor placements and register settings comes
// first. Random traffic follows: one long line that runs the column past 255,
// then phases under assorted register settings. Every accepted item is fed to
// a cycle-free model of the cursor logic. The model queues the nibbles that
// the item must produce, and each nibble taken from the result channel is
// compared with the oldest one in that queue. Both sides of the data path
// idle at random. One phase holds the result side off long enough to back
// the block up into its input.
// ----------------------------------------------------------------------------
module char_lcd_text_writer_top_test;
   import clcd_pkg::*;

   localparam int          HALF_PERIOD  = 10;
   localparam int          RESET_CYCLES = 11;
   localparam int          LONG_HOLD    = 150;
   localparam int          REPORT_LIMIT = 10;
   localparam logic [7:0]  FILLER_CHAR  = 8'h2E;
   localparam logic [7:0]  LINE_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

   // One row of the scripted part. known_bytes > 0 means the expected bytes
   // are typed in below ({rs, byte}, first byte in the top nine bits) and
   // replace what the model predicts for that item.
   typedef struct packed {
      logic        reconfigure;
      cfg_type     settings;
      req_type     item;
      logic [1:0]  known_bytes;
      logic [26:0] known;
   } step_row_type;

   localparam cfg_type KEEP = '0;

   localparam step_row_type SCRIPT [18] = '{
      // data straight after reset, cursor at row 0, column 0
      '{1'b0, KEEP, '{1'b0, 3'd0, 7'd0, 8'h41}, 2'd1, {RS_DATA, 8'h41, 18'h0}},
      // smallest placement and a zero byte
      '{1'b0, KEEP, '{1'b1, 3'd0, 7'd0, 8'h00}, 2'd2,
        {RS_INSTR, 8'h80, RS_DATA, 8'h00, 9'h0}},
      // largest fields: row 7 falls back to row 0
      '{1'b0, KEEP, '{1'b1, 3'd7, 7'd127, 8'hFF}, 2'd2,
        {RS_INSTR, 8'hFF, RS_DATA, 8'hFF, 9'h0}},
      // newline from the last row in use goes back to row 0, column kept
      '{1'b0, KEEP, '{1'b1, 3'd1, 7'd127, CHAR_NEWLINE}, 2'd2,
        {RS_INSTR, 8'hBF, RS_INSTR, 8'hFF, 9'h0}},
      '{1'b0, KEEP, '{1'b0, 3'd0, 7'd0, CHAR_RETURN}, 2'd1, {RS_INSTR, 8'h80, 18'h0}},
      '{1'b0, KEEP, '{1'b1, 3'd1, 7'd5, CHAR_RETURN}, 2'd2,
        {RS_INSTR, 8'hC5, RS_INSTR, 8'hC0, 9'h0}},
      '{1'b0, KEEP, '{1'b0, 3'd0, 7'd0, CHAR_NEWLINE}, 2'd0, 27'h0},
      // placement fields without set_position are ignored
      '{1'b0, KEEP, '{1'b0, 3'd3, 7'd85, 8'h7E}, 2'd0, 27'h0},
      // all four rows, wrap on: six nibbles in one item
      '{1'b1, '{3'd4, 7'd80, 1'b1}, '{1'b1, 3'd3, 7'd127, 8'h41}, 2'd3,
        {RS_INSTR, 8'hD3, RS_INSTR, 8'h80, RS_DATA, 8'h41}},
      '{1'b0, KEEP, '{1'b1, 3'd2, 7'd79, 8'h42}, 2'd0, 27'h0},
      '{1'b0, KEEP, '{1'b0, 3'd0, 7'd0, 8'h43}, 2'd0, 27'h0},
      '{1'b0, KEEP, '{1'b0, 3'd0, 7'd0, CHAR_NEWLINE}, 2'd0, 27'h0},
      // zero rows and zero columns with wrap: wrap before every character
      '{1'b1, '{3'd0, 7'd0, 1'b1}, '{1'b1, 3'd2, 7'd10, 8'h55}, 2'd0, 27'h0},
      '{1'b0, KEEP, '{1'b0, 3'd0, 7'd0, CHAR_RETURN}, 2'd0, 27'h0},
      // rows above four act as four
      '{1'b1, '{3'd7, 7'd1, 1'b0}, '{1'b1, 3'd3, 7'd0, CHAR_NEWLINE}, 2'd2,
        {RS_INSTR, 8'hD4, RS_INSTR, 8'h80, 9'h0}},
      '{1'b0, KEEP, '{1'b1, 3'd4, 7'd1, 8'h20}, 2'd0, 27'h0},
      '{1'b0, KEEP, '{1'b0, 3'd0, 7'd0, 8'h5A}, 2'd0, 27'h0},
      // a single row: every newline lands on row 0
      '{1'b1, '{3'd1, 7'd127, 1'b1}, '{1'b0, 3'd0, 7'd0, CHAR_NEWLINE}, 2'd0, 27'h0}
   };

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   req_type     req_data     = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel     = 1'b0;
   logic        csr_penable  = 1'b0;
   logic        csr_pwrite   = 1'b0;
   logic [3:0]  csr_paddr    = '0;
   logic [31:0] csr_pwdata   = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Model state: register copies and the cursor
   logic [2:0]  rows_setting = ROWS_RESET;
   logic [6:0]  cols_setting = COLS_RESET;
   logic        wrap_setting = 1'b0;
   logic [1:0]  cursor_row   = 2'd0;
   logic [7:0]  cursor_col   = 8'd0;

   // Nibbles of the item being predicted, then the queue the checker pops
   rsp_type     run_nibbles [6];
   int          run_len;
   rsp_type     pending_nibbles [$];

   int          mismatch_count = 0;
   logic        calm           = 1'b0;   // no idling on either side
   logic        hold_pending   = 1'b0;   // ask the receiver for one long hold

   char_lcd_text_writer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Cursor model
   // ------------------------------------------------------------------------

   // Split one byte into two nibbles, high first
   function automatic void add_byte(input logic rs, input logic [7:0] code);
      run_nibbles[run_len]     = '{rs, code[7:4], 1'b0};
      run_nibbles[run_len + 1] = '{rs, code[3:0], 1'b0};
      run_len += 2;
   endfunction

   // Move the cursor and emit the set-address instruction. A row at or past
   // the rows in use (capped at four) lands on row 0.
   function automatic void move_cursor(input logic [2:0] row, input logic [7:0] col);
      logic [2:0] row_count;
      row_count = (rows_setting > ROWS_MAX) ? ROWS_MAX : rows_setting;
      if (row >= row_count) begin
         row = 3'd0;
      end
      cursor_row = row[1:0];
      cursor_col = col;
      add_byte(RS_INSTR, CMD_SET_ADDR | (cursor_col + LINE_START[cursor_row]));
   endfunction

   // Work out the nibbles of one character and advance the cursor
   function automatic void predict_char(input req_type it);
      run_len = 0;
      if (it.set_position) begin
         move_cursor(it.start_row, {1'b0, it.start_col});
      end
      if (wrap_setting && cursor_col >= {1'b0, cols_setting}) begin
         move_cursor({1'b0, cursor_row} + 3'd1, 8'd0);
      end
      if (it.char_code == CHAR_NEWLINE) begin
         move_cursor({1'b0, cursor_row} + 3'd1, cursor_col);
      end else if (it.char_code == CHAR_RETURN) begin
         move_cursor({1'b0, cursor_row}, 8'd0);
      end else begin
         add_byte(RS_DATA, it.char_code);
         cursor_col = cursor_col + 8'd1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // Mostly no gap, some short ones, a few long ones
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Offer one item, hold it until accepted, then queue what it must produce.
   // Entered and left just after a rising edge.
   task automatic offer_char(input req_type it, input logic [1:0] known_bytes,
                             input logic [26:0] known);
      int gap;
      int k;
      gap = gap_length();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      predict_char(it);
      // Typed-in bytes override the model where the script gives them
      if (known_bytes != 2'd0) begin
         run_len = 0;
         for (k = 0; k < known_bytes; k++) begin
            add_byte(known[26 - 9 * k], known[25 - 9 * k -: 8]);
         end
      end
      run_nibbles[run_len - 1].last_of_run = 1'b1;
      for (k = 0; k < run_len; k++) begin
         pending_nibbles.push_back(run_nibbles[k]);
      end
   endtask

   // Drop valid and wait until every queued nibble has come out
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_nibbles.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Setup cycle then access cycle; psel stays up across back-to-back writes
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Write all three registers; only call while the block is idle
   task automatic apply_settings(input cfg_type c);
      csr_write(REG_ROWS, {29'd0, c.rows_in_use});
      csr_write(REG_COLS, {25'd0, c.cols_in_use});
      csr_write(REG_WRAP, {31'd0, c.wrap_long_lines});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      rows_setting = c.rows_in_use;
      cols_setting = c.cols_in_use;
      wrap_setting = c.wrap_long_lines;
   endtask

   // Random character: newlines and returns often, placements now and then,
   // columns biased toward both ends
   function automatic req_type random_char();
      req_type r;
      int      roll;
      r.set_position = ($urandom_range(0, 3) == 0);
      r.start_row    = 3'($urandom_range(0, 7));
      roll = $urandom_range(0, 9);
      r.start_col    = (roll == 0) ? 7'd0 : (roll == 1) ? 7'd127 : 7'($urandom_range(0, 127));
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         r.char_code = CHAR_NEWLINE;
      end else if (roll < 20) begin
         r.char_code = CHAR_RETURN;
      end else begin
         r.char_code = 8'($urandom_range(0, 255));
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: alternate runs of taking nibbles with stalls. One long hold
   // is served on request, counted here in cycles.
   // ------------------------------------------------------------------------
   initial begin
      int n;
      forever begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            @(posedge clock);
            rsp_stall <= 1'b0;
         end
         if (hold_pending) begin
            hold_pending = 1'b0;
            n = LONG_HOLD;
         end else begin
            n = gap_length();
         end
         repeat (n) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compare every nibble taken with the oldest one expected
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_nibbles.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected nibble rs=%0d nibble=%h last=%0d",
                        rsp_data.register_select, rsp_data.nibble, rsp_data.last_of_run);
            end
         end else begin
            want = pending_nibbles.pop_front();
            if (rsp_data.register_select !== want.register_select ||
                rsp_data.nibble !== want.nibble ||
                rsp_data.last_of_run !== want.last_of_run) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: want rs=%0d nib=%h last=%0d, got rs=%0d nib=%h last=%0d",
                           want.register_select, want.nibble, want.last_of_run,
                           rsp_data.register_select, rsp_data.nibble, rsp_data.last_of_run);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int      i;
      int      k;
      int      phase;
      int      count;
      req_type it;
      cfg_type c;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Scripted part: register changes only between drained items
      for (i = 0; i < $size(SCRIPT); i++) begin
         if (SCRIPT[i].reconfigure) begin
            drain();
            apply_settings(SCRIPT[i].settings);
         end
         offer_char(SCRIPT[i].item, SCRIPT[i].known_bytes, SCRIPT[i].known);
      end

      // One long line with wrap off: run the column past 255 so both the
      // column and the address sum roll over. Keep returns out of it.
      drain();
      apply_settings('{3'd3, 7'd127, 1'b0});
      offer_char('{1'b1, 3'($urandom_range(0, 2)), 7'd127, 8'h41}, 2'd0, 27'h0);
      for (k = 0; k < 150; k++) begin
         it = random_char();
         it.set_position = 1'b0;
         if (k % 16 == 15) begin
            it.char_code = CHAR_NEWLINE;
         end else if (it.char_code == CHAR_RETURN || it.char_code == CHAR_NEWLINE) begin
            it.char_code = FILLER_CHAR;
         end
         offer_char(it, 2'd0, 27'h0);
      end

      // Random phases; two with no idling, one of them with a long hold at the output
      for (phase = 0; phase < 6; phase++) begin
         drain();
         c.rows_in_use = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 4))
            0: begin
               c.cols_in_use = 7'd0;
            end
            1: begin
               c.cols_in_use = 7'd1;
            end
            2: begin
               c.cols_in_use = 7'd127;
            end
            default: begin
               c.cols_in_use = 7'($urandom_range(2, 40));
            end
         endcase
         c.wrap_long_lines = (phase % 2 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
         apply_settings(c);
         calm = (phase == 2 || phase == 3);
         if (phase == 3) begin
            hold_pending = 1'b1;
         end
         count = $urandom_range(22, 26);
         for (k = 0; k < count; k++) begin
            offer_char(random_char(), 2'd0, 27'h0);
         end
         calm = 1'b0;
      end

      // Let the last nibbles out, then watch a little longer for strays
      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_nibbles.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard stop if the handshakes hang
   initial begin
      #10000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: char_lcd_text_writer_top.f
src/clcd_pkg.sv
src/clcd_planner.sv
src/char_lcd_text_writer_top.sv
bench/char_lcd_text_writer_top_test.sv
